// ----- rtl/core/ppe_pkg.sv -----
`default_nettype none
package ppe_pkg;

	// Command codes.
	localparam logic [1:0] CMD_EMIT   = 2'd0;
	localparam logic [1:0] CMD_UPDATE = 2'd1;
	localparam logic [1:0] CMD_DRAW   = 2'd2;

	// Random generator constants.
	localparam logic [31:0] LCG_MUL  = 32'd1664525;
	localparam logic [31:0] LCG_ADD  = 32'd1013904223;
	localparam logic [31:0] RNG_SEED = 32'd12345;

	// Most particles streamed by one draw transaction.
	localparam int MAX_DRAWN = 32;

	// Divider geometry: quotients fit 15 bits, dividends 40 bits.
	localparam int DIV_N = 15;
	localparam int DVD_W = 40;
	localparam int DVS_W = 24;

	// Shared multiplier operand and product widths.
	localparam int MA_W = 34;
	localparam int MB_W = 22;
	localparam int MP_W = MA_W + MB_W;

	typedef struct packed {
		logic [1:0]          cmd;
		logic signed [31:0]  origin_x;
		logic signed [31:0]  origin_y;
		logic [23:0]         tint;
		logic [5:0]          burst_count;
		logic [31:0]         base_speed;
		logic [23:0]         base_life;
		logic [15:0]         time_step;
	} src_t;

	typedef struct packed {
		logic                has_particle;
		logic signed [31:0]  draw_x;
		logic signed [31:0]  draw_y;
		logic [14:0]         radius;
		logic [31:0]         rgba;
		logic [5:0]          spawned;
		logic                last;
	} dst_t;

	// One particle record as held in the pool memory.
	typedef struct packed {
		logic signed [31:0]  pos_x;
		logic signed [31:0]  pos_y;
		logic signed [31:0]  vel_x;
		logic signed [31:0]  vel_y;
		logic [23:0]         colour;
		logic [23:0]         life_left;
		logic [23:0]         life_start;
		logic [15:0]         size;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	// Arithmetic shift right that truncates toward zero.
	function automatic logic signed [MP_W-1:0] shr_tz(input logic signed [MP_W-1:0] p,
		input int s);
		logic signed [MP_W-1:0] bias;
		bias = p[MP_W-1] ? ((MP_W'(1) <<< s) - MP_W'(1)) : '0;
		return (p + bias) >>> s;
	endfunction

	// Saturate to the signed 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [MP_W-1:0] v);
		if (v > MP_W'(64'sd2147483647)) begin
			return 32'sh7FFF_FFFF;
		end else if (v < -MP_W'(64'sd2147483648)) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	// Quarter-wave sine entry k in Q1.15, by a fixed-point Taylor series.
	function automatic logic [15:0] sine_calc(input int k, input int bits);
		logic [63:0] x;
		logic [63:0] t;
		logic [63:0] sum;
		logic [63:0] q;
		x = (64'd1686629713 * 64'(k)) >> bits;
		t = x;
		sum = x;
		t = (((t * x) >> 30) * x) >> 30;
		t = t / 64'd6;
		sum = sum - t;
		t = (((t * x) >> 30) * x) >> 30;
		t = t / 64'd20;
		sum = sum + t;
		t = (((t * x) >> 30) * x) >> 30;
		t = t / 64'd42;
		sum = sum - t;
		t = (((t * x) >> 30) * x) >> 30;
		t = t / 64'd72;
		sum = sum + t;
		t = (((t * x) >> 30) * x) >> 30;
		t = t / 64'd110;
		sum = sum - t;
		t = (((t * x) >> 30) * x) >> 30;
		t = t / 64'd156;
		sum = sum + t;
		q = (sum + 64'd16384) >> 15;
		return (q > 64'd32767) ? 16'd32767 : q[15:0];
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/ppe_ram.sv -----
`default_nettype none
module ppe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0]      rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];
	logic [WIDTH-1:0] rdata_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- rtl/core/ppe_div.sv -----
`default_nettype none
module ppe_div (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [ppe_pkg::DVD_W-1:0] dividend,
	input  wire logic [ppe_pkg::DVS_W-1:0] divisor,
	output logic                          done,
	output logic [ppe_pkg::DIV_N-1:0]     quot
);
	import ppe_pkg::*;

	localparam int CNT_W = $clog2(DIV_N);

	logic [DVD_W-1:0] rem_q;
	logic [DVD_W-1:0] dsh_q;
	logic [DIV_N-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             fits;

	// The dividend must be below divisor times 2^DIV_N.
	assign fits = (rem_q >= dsh_q);

	// Restoring division, one quotient bit per cycle, most significant first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DIV_N - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsh_q <= DVD_W'(divisor) << (DIV_N - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[DIV_N-2:0], fits};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule
`default_nettype wire

// ----- rtl/core/particle_pool_engine.sv -----
`default_nettype none
// Emit scans for free slots and builds each spawned particle, update steps each live
// particle, and draw streams up to MAX_DRAWN live particles; the result side can stall.
// The per-slot read-modify-write of the pool memory and the shared multiplier set the
// pace; in draw the 15-step alpha and radius dividers dominate.
// One command is worked at a time; the next is taken after its closing item is queued.
// Reset (arst_n, asynchronous) frees every slot and reloads the random seed.
module particle_pool_engine #(
	parameter int POOL_SIZE = 32,
	parameter int SINE_TABLE_BITS = 8
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           src_valid,
	output logic                src_stall,
	input  wire ppe_pkg::src_t  src_data,
	output logic                dst_valid,
	input  wire logic           dst_stall,
	output ppe_pkg::dst_t       dst_data
);
	import ppe_pkg::*;

	localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
	localparam int CW = $clog2(POOL_SIZE + 1);
	localparam int SB = SINE_TABLE_BITS;
	localparam int SE = (1 << SB) + 1;

	typedef enum logic [24:0] {
		S_IDLE   = 25'h0000001,
		S_E_SCAN = 25'h0000002,
		S_E_RNG  = 25'h0000004,
		S_E_RNGW = 25'h0000008,
		S_E_F    = 25'h0000010,
		S_E_SPD  = 25'h0000020,
		S_E_SPDW = 25'h0000040,
		S_E_VX   = 25'h0000080,
		S_E_VY   = 25'h0000100,
		S_E_VYW  = 25'h0000200,
		S_E_LIFE = 25'h0000400,
		S_E_LIFW = 25'h0000800,
		S_E_WR   = 25'h0001000,
		S_U_SCAN = 25'h0002000,
		S_U_PX   = 25'h0004000,
		S_U_PY   = 25'h0008000,
		S_U_VX   = 25'h0010000,
		S_U_VY   = 25'h0020000,
		S_U_WR   = 25'h0040000,
		S_D_SCAN = 25'h0080000,
		S_D_MUL  = 25'h0100000,
		S_D_DIV  = 25'h0200000,
		S_D_WAIT = 25'h0400000,
		S_D_OUT  = 25'h0800000,
		S_DONE   = 25'h1000000
	} state_t;

	state_t                  state_q;
	src_t                    in_q;
	logic [POOL_SIZE-1:0]    alive_q;
	logic [CW-1:0]           idx_q;
	logic [5:0]              n_q;
	logic [5:0]              k_q;
	logic [1:0]              draw_q;
	logic [31:0]             rng_q;
	logic [15:0]             ph_q;
	logic [15:0]             r_q;
	logic [31:0]             spd_q;
	logic signed [31:0]      vx_q;
	logic signed [31:0]      vy_q;
	logic signed [31:0]      px_q;
	logic signed [31:0]      py_q;
	logic [23:0]             life_q;
	logic [15:0]             size_q;
	logic [7:0]              alpha_q;
	logic [14:0]             rad_q;
	rec_t                    rec_q;
	logic signed [MP_W-1:0]  p_q;
	logic                    dst_valid_q;
	dst_t                    dst_q;

	logic signed [MA_W-1:0]  ma_d;
	logic signed [MB_W-1:0]  mb_d;
	logic                    ram_we;
	logic                    ram_re;
	rec_t                    ram_wdata;
	rec_t                    ram_rdata;
	logic [AW-1:0]           slot;
	logic                    pool_end;
	logic                    cur_alive;
	logic                    out_free;
	logic                    push_out;
	logic [31:0]             rnd;
	logic [15:0]             f_val;
	logic signed [17:0]      drag;
	logic signed [31:0]      vy_upd;
	logic                    life_out;
	logic [15:0]             sine_tab [0:SE-1];
	logic [15:0]             look_ph;
	logic [SB:0]             tab_idx;
	logic signed [15:0]      sine_val;
	logic                    div_start;
	logic [DVD_W-1:0]        alpha_dvd;
	logic                    div_a_done;
	logic                    div_r_done;
	logic [DIV_N-1:0]        div_a_quot;
	logic [DIV_N-1:0]        div_r_quot;

	// Quarter-wave sine table, built at elaboration.
	for (genvar gk = 0; gk < SE; gk++) begin : g_sine
		assign sine_tab[gk] = sine_calc(gk, SB);
	end

	// One table lookup: cosine while forming x velocity, sine otherwise.
	always_comb begin
		look_ph = (state_q == S_E_VX) ? (ph_q + 16'd16384) : ph_q;
		tab_idx = look_ph[14] ? ((SB+1)'(SE - 1) - {1'b0, look_ph[13 -: SB]})
			: {1'b0, look_ph[13 -: SB]};
		sine_val = look_ph[15] ? -$signed(sine_tab[tab_idx]) : $signed(sine_tab[tab_idx]);
	end

	assign slot      = idx_q[AW-1:0];
	assign pool_end  = (idx_q == CW'(POOL_SIZE));
	assign cur_alive = alive_q[slot];
	assign out_free  = !dst_valid_q || !dst_stall;
	assign push_out  = ((state_q == S_D_OUT) || (state_q == S_DONE)) && out_free;
	assign rnd       = p_q[31:0] + LCG_ADD;
	assign f_val     = 16'd19661 + p_q[31:16];
	assign drag      = 18'sd65536 - $signed({1'b0, in_q.time_step, 1'b0});
	assign vy_upd    = sat32(shr_tz(p_q, 16));
	assign life_out  = (rec_q.life_left <= {8'd0, in_q.time_step});
	assign alpha_dvd = DVD_W'({rec_q.life_left, 8'd0} - {8'd0, rec_q.life_left});
	assign div_start = (state_q == S_D_DIV) && (rec_q.life_start != '0);

	// Operand selection for the shared multiplier.
	always_comb begin
		ma_d = '0;
		mb_d = '0;
		case (state_q)
			S_E_RNG: begin
				ma_d = {2'b00, rng_q};
				mb_d = MB_W'(LCG_MUL);
			end
			S_E_F: begin
				ma_d = MA_W'(r_q);
				mb_d = MB_W'(45875);
			end
			S_E_SPD: begin
				ma_d = {2'b00, in_q.base_speed};
				mb_d = MB_W'(f_val);
			end
			S_E_VX, S_E_VY: begin
				ma_d = {2'b00, spd_q};
				mb_d = MB_W'(sine_val);
			end
			S_E_LIFE: begin
				ma_d = MA_W'(in_q.base_life);
				mb_d = MB_W'({1'b1, r_q[15:1]});
			end
			S_U_PX: begin
				ma_d = MA_W'(ram_rdata.vel_x);
				mb_d = MB_W'(in_q.time_step);
			end
			S_U_PY: begin
				ma_d = MA_W'(rec_q.vel_y);
				mb_d = MB_W'(in_q.time_step);
			end
			S_U_VX: begin
				ma_d = MA_W'(rec_q.vel_x);
				mb_d = MB_W'(drag);
			end
			S_U_VY: begin
				ma_d = MA_W'(rec_q.vel_y);
				mb_d = MB_W'(drag);
			end
			S_D_MUL: begin
				ma_d = MA_W'(ram_rdata.life_left);
				mb_d = MB_W'(ram_rdata.size);
			end
			default: begin
				ma_d = '0;
				mb_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		p_q <= ma_d * mb_d;
	end

	// Pool memory port control.
	always_comb begin
		ram_re    = ((state_q == S_U_SCAN) || (state_q == S_D_SCAN)) && !pool_end
			&& cur_alive;
		ram_we    = (state_q == S_E_WR) || (state_q == S_U_WR);
		ram_wdata = rec_q;
		if (state_q == S_E_WR) begin
			ram_wdata.pos_x      = in_q.origin_x;
			ram_wdata.pos_y      = in_q.origin_y;
			ram_wdata.vel_x      = vx_q;
			ram_wdata.vel_y      = vy_q;
			ram_wdata.colour     = in_q.tint;
			ram_wdata.life_left  = life_q;
			ram_wdata.life_start = life_q;
			ram_wdata.size       = size_q;
		end else begin
			ram_wdata.pos_x     = px_q;
			ram_wdata.pos_y     = py_q;
			ram_wdata.vel_x     = vx_q;
			ram_wdata.vel_y     = vy_upd;
			ram_wdata.life_left = life_out ? '0 : (rec_q.life_left - {8'd0, in_q.time_step});
		end
	end

	ppe_ram #(
		.WIDTH (REC_W),
		.DEPTH (POOL_SIZE)
	) u_pool (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (slot),
		.rdata (ram_rdata)
	);

	ppe_div u_div_alpha (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (alpha_dvd),
		.divisor  (rec_q.life_start),
		.done     (div_a_done),
		.quot     (div_a_quot)
	);

	ppe_div u_div_radius (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (p_q[DVD_W-1:0]),
		.divisor  (rec_q.life_start),
		.done     (div_r_done),
		.quot     (div_r_quot)
	);

	// Command sequencer: walks the pool one slot at a time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			alive_q     <= '0;
			idx_q       <= '0;
			n_q         <= '0;
			k_q         <= '0;
			draw_q      <= '0;
			rng_q       <= RNG_SEED;
			dst_valid_q <= 1'b0;
		end else begin
			if (push_out) begin
				dst_valid_q <= 1'b1;
			end else if (!dst_stall) begin
				dst_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (src_valid) begin
						idx_q <= '0;
						n_q   <= '0;
						k_q   <= '0;
						case (src_data.cmd)
							CMD_EMIT:   state_q <= S_E_SCAN;
							CMD_UPDATE: state_q <= S_U_SCAN;
							CMD_DRAW:   state_q <= S_D_SCAN;
							default:    state_q <= S_DONE;
						endcase
					end
				end
				S_E_SCAN: begin
					if (pool_end || (n_q >= in_q.burst_count)) begin
						state_q <= S_DONE;
					end else if (cur_alive) begin
						idx_q <= idx_q + CW'(1);
					end else begin
						draw_q  <= 2'd0;
						state_q <= S_E_RNG;
					end
				end
				S_E_RNG: state_q <= S_E_RNGW;
				S_E_RNGW: begin
					rng_q <= rnd;
					case (draw_q)
						2'd0: begin
							draw_q  <= 2'd1;
							state_q <= S_E_RNG;
						end
						2'd1: state_q <= S_E_F;
						2'd2: state_q <= S_E_LIFE;
						default: state_q <= S_E_WR;
					endcase
				end
				S_E_F:    state_q <= S_E_SPD;
				S_E_SPD:  state_q <= S_E_SPDW;
				S_E_SPDW: state_q <= S_E_VX;
				S_E_VX:   state_q <= S_E_VY;
				S_E_VY:   state_q <= S_E_VYW;
				S_E_VYW: begin
					draw_q  <= 2'd2;
					state_q <= S_E_RNG;
				end
				S_E_LIFE: state_q <= S_E_LIFW;
				S_E_LIFW: begin
					draw_q  <= 2'd3;
					state_q <= S_E_RNG;
				end
				S_E_WR: begin
					alive_q[slot] <= 1'b1;
					n_q     <= n_q + 6'd1;
					idx_q   <= idx_q + CW'(1);
					state_q <= S_E_SCAN;
				end
				S_U_SCAN: begin
					if (pool_end) begin
						state_q <= S_DONE;
					end else if (cur_alive) begin
						state_q <= S_U_PX;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				S_U_PX: state_q <= S_U_PY;
				S_U_PY: state_q <= S_U_VX;
				S_U_VX: state_q <= S_U_VY;
				S_U_VY: state_q <= S_U_WR;
				S_U_WR: begin
					if (life_out) begin
						alive_q[slot] <= 1'b0;
					end
					idx_q   <= idx_q + CW'(1);
					state_q <= S_U_SCAN;
				end
				S_D_SCAN: begin
					if (pool_end || (k_q == 6'(MAX_DRAWN))) begin
						state_q <= S_DONE;
					end else if (cur_alive) begin
						state_q <= S_D_MUL;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				S_D_MUL: state_q <= S_D_DIV;
				S_D_DIV: state_q <= (rec_q.life_start == '0) ? S_D_OUT : S_D_WAIT;
				S_D_WAIT: begin
					if (div_a_done && div_r_done) begin
						state_q <= S_D_OUT;
					end
				end
				S_D_OUT: begin
					if (out_free) begin
						k_q     <= k_q + 6'd1;
						idx_q   <= idx_q + CW'(1);
						state_q <= S_D_SCAN;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers; they need no reset.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				in_q <= src_data;
			end
			S_E_RNGW: begin
				if (draw_q == 2'd0) begin
					ph_q <= rnd[31:16];
				end
				r_q    <= rnd[31:16];
				size_q <= 16'd8192 + {2'b00, rnd[31:18]};
			end
			S_E_SPDW: spd_q <= p_q[47:16];
			S_E_VY:   vx_q <= sat32(shr_tz(p_q, 15));
			S_E_VYW:  vy_q <= sat32(shr_tz(p_q, 15));
			S_E_LIFW: life_q <= p_q[39:16];
			S_U_PX:   rec_q <= ram_rdata;
			S_U_PY:   px_q <= sat32(MP_W'(rec_q.pos_x) + shr_tz(p_q, 16));
			S_U_VX:   py_q <= sat32(MP_W'(rec_q.pos_y) + shr_tz(p_q, 16));
			S_U_VY:   vx_q <= sat32(shr_tz(p_q, 16));
			S_D_MUL:  rec_q <= ram_rdata;
			S_D_DIV: begin
				alpha_q <= '0;
				rad_q   <= '0;
			end
			S_D_WAIT: begin
				alpha_q <= div_a_quot[7:0];
				rad_q   <= div_r_quot;
			end
			default: begin
			end
		endcase
	end

	// Result register.
	always_ff @(posedge clk) begin
		if ((state_q == S_D_OUT) && out_free) begin
			dst_q.has_particle <= 1'b1;
			dst_q.draw_x       <= rec_q.pos_x;
			dst_q.draw_y       <= rec_q.pos_y;
			dst_q.radius       <= rad_q;
			dst_q.rgba         <= {rec_q.colour, alpha_q};
			dst_q.spawned      <= '0;
			dst_q.last         <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			dst_q.has_particle <= 1'b0;
			dst_q.draw_x       <= '0;
			dst_q.draw_y       <= '0;
			dst_q.radius       <= '0;
			dst_q.rgba         <= '0;
			dst_q.spawned      <= (in_q.cmd == CMD_EMIT) ? n_q : 6'd0;
			dst_q.last         <= 1'b1;
		end
	end

	assign src_stall = (state_q != S_IDLE);
	assign dst_valid = dst_valid_q;
	assign dst_data  = dst_q;

	// An accepted transaction always leaves the idle state.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(src_valid && !src_stall) |=> (state_q != S_IDLE))
		else $error("accepted transaction did not start");

	// Emit only fills a slot while under the requested count and on a free slot.
	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_E_WR) |-> ((n_q < in_q.burst_count) && !cur_alive))
		else $error("emit overran its count or hit a live slot");

	// Update writes back only live slots.
	a_update_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_U_WR) |-> cur_alive)
		else $error("update wrote a free slot");

	// Both dividers run in lock step.
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		div_a_done == div_r_done)
		else $error("dividers out of step");

endmodule
`default_nettype wire

// ----- bench/particle_pool_engine_test.sv -----
`default_nettype none
module particle_pool_engine_test;
	import ppe_pkg::*;

	localparam int POOL = 32;
	localparam int TBL_BITS = 8;
	localparam int HOLD_CYCLES = 2000;
	localparam int IDLE_LIMIT = 20000;
	localparam int RANDOM_ITEMS = 320;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// Scoreboard: a cycle-free model of the particle pool plus the queue of draw-list
	// items it predicts.
	class particle_scoreboard;
		dst_t pending_q[$];
		int errors;
		bit live[POOL];
		logic signed [31:0] px[POOL];
		logic signed [31:0] py[POOL];
		logic signed [31:0] vx[POOL];
		logic signed [31:0] vy[POOL];
		logic [23:0] hue[POOL];
		logic [23:0] life_now[POOL];
		logic [23:0] life_init[POOL];
		logic [15:0] radius_base[POOL];
		logic [31:0] lcg;
		logic [15:0] quarter_sine[(1 << TBL_BITS) + 1];

		function new();
			longint unsigned x, t, acc, q;
			for (int k = 0; k <= (1 << TBL_BITS); k++) begin
				x = (64'd1686629713 * longint'(k)) >> TBL_BITS;
				t = x;
				acc = x;
				for (int n = 1; n <= 6; n++) begin
					t = (((t * x) >> 30) * x) >> 30;
					t = t / longint'((2 * n) * (2 * n + 1));
					if (n % 2 == 1) begin
						acc = acc - t;
					end else begin
						acc = acc + t;
					end
				end
				q = (acc + 64'd16384) >> 15;
				quarter_sine[k] = (q > 64'd32767) ? 16'd32767 : q[15:0];
			end
			for (int i = 0; i < POOL; i++) begin
				live[i] = 1'b0;
			end
			lcg = RNG_SEED;
			errors = 0;
		endfunction

		function int pending();
			return pending_q.size();
		endfunction

		function longint unsigned roll();
			lcg = lcg * LCG_MUL + LCG_ADD;
			return longint'(lcg[31:16]);
		endfunction

		function longint sine_at(logic [15:0] phase);
			int idx;
			longint v;
			idx = phase[13:14-TBL_BITS];
			if (phase[14]) begin
				idx = (1 << TBL_BITS) - idx;
			end
			v = longint'(quarter_sine[idx]);
			return phase[15] ? -v : v;
		endfunction

		// Product shifted right with truncation toward zero.
		function longint scaled_product(longint a, longint b, int s);
			bit neg;
			longint unsigned ua, ub, m;
			neg = (a < 0) != (b < 0);
			ua = (a < 0) ? -a : a;
			ub = (b < 0) ? -b : b;
			m = (ua * ub) >> s;
			return neg ? -longint'(m) : longint'(m);
		endfunction

		function logic signed [31:0] clamp32(longint v);
			if (v > 64'sd2147483647) begin
				return 32'sh7FFF_FFFF;
			end else if (v < -64'sd2147483648) begin
				return 32'sh8000_0000;
			end
			return v[31:0];
		endfunction

		// Works out the items that an accepted command transaction produces.
		function void note_command(src_t c);
			dst_t d;
			int n, shown;
			longint unsigned ph, r, f, spd, alpha, rad, dt;
			longint drag;
			d = '0;
			d.last = 1'b1;
			case (c.cmd)
				CMD_EMIT: begin
					n = 0;
					for (int i = 0; i < POOL && n < c.burst_count; i++) begin
						if (!live[i]) begin
							ph = roll();
							r = roll();
							f = 19661 + ((45875 * r) >> 16);
							spd = (longint'(c.base_speed) * f) >> 16;
							vx[i] = clamp32(scaled_product(spd, sine_at(ph + 16384), 15));
							vy[i] = clamp32(scaled_product(spd, sine_at(ph), 15));
							px[i] = c.origin_x;
							py[i] = c.origin_y;
							hue[i] = c.tint;
							r = roll();
							life_now[i] = (longint'(c.base_life) * (32768 + (r >> 1))) >> 16;
							life_init[i] = life_now[i];
							r = roll();
							radius_base[i] = 8192 + (r >> 2);
							live[i] = 1'b1;
							n++;
						end
					end
					d.spawned = n;
					pending_q.push_back(d);
				end
				CMD_UPDATE: begin
					dt = c.time_step;
					drag = 65536 - 2 * longint'(dt);
					for (int i = 0; i < POOL; i++) begin
						if (live[i]) begin
							px[i] = clamp32(longint'(px[i]) + scaled_product(vx[i], dt, 16));
							py[i] = clamp32(longint'(py[i]) + scaled_product(vy[i], dt, 16));
							vx[i] = clamp32(scaled_product(vx[i], drag, 16));
							vy[i] = clamp32(scaled_product(vy[i], drag, 16));
							if (life_now[i] <= dt) begin
								life_now[i] = '0;
								live[i] = 1'b0;
							end else begin
								life_now[i] = life_now[i] - dt;
							end
						end
					end
					pending_q.push_back(d);
				end
				CMD_DRAW: begin
					shown = 0;
					for (int i = 0; i < POOL && shown < MAX_DRAWN; i++) begin
						if (live[i]) begin
							alpha = 0;
							rad = 0;
							if (life_init[i] != 0) begin
								alpha = (longint'(life_now[i]) * 255) / life_init[i];
								rad = (longint'(radius_base[i]) * life_now[i]) / life_init[i];
							end
							d = '0;
							d.has_particle = 1'b1;
							d.draw_x = px[i];
							d.draw_y = py[i];
							d.radius = rad[14:0];
							d.rgba = {hue[i], alpha[7:0]};
							pending_q.push_back(d);
							shown++;
						end
					end
					d = '0;
					d.last = 1'b1;
					pending_q.push_back(d);
				end
				default: begin
					pending_q.push_back(d);
				end
			endcase
		endfunction

		// Compares one accepted result transaction with the oldest prediction.
		function void check_item(dst_t got);
			dst_t want;
			if (pending_q.size() == 0) begin
				$error("result with no prediction pending: %h", got);
				errors++;
				return;
			end
			want = pending_q.pop_front();
			if (got.has_particle !== want.has_particle) begin
				$error("has_particle: expected %0d, got %0d", want.has_particle,
					got.has_particle);
				errors++;
			end
			if (got.draw_x !== want.draw_x) begin
				$error("draw_x: expected %h, got %h", want.draw_x, got.draw_x);
				errors++;
			end
			if (got.draw_y !== want.draw_y) begin
				$error("draw_y: expected %h, got %h", want.draw_y, got.draw_y);
				errors++;
			end
			if (got.radius !== want.radius) begin
				$error("radius: expected %h, got %h", want.radius, got.radius);
				errors++;
			end
			if (got.rgba !== want.rgba) begin
				$error("rgba: expected %h, got %h", want.rgba, got.rgba);
				errors++;
			end
			if (got.spawned !== want.spawned) begin
				$error("spawned: expected %0d, got %0d", want.spawned, got.spawned);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic src_valid = 1'b0;
	src_t src_data = '0;
	logic dst_stall = 1'b0;
	logic src_stall;
	logic dst_valid;
	dst_t dst_data;

	particle_scoreboard sb = new();
	bit calm = 1'b0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int stall_left = 0;
	int idle_cycles = 0;

	particle_pool_engine u_top (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_data(src_data),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.dst_data(dst_data)
	);

	always #1 clk = ~clk;

	// Short gaps are common, long ones rare; calm phases have none.
	function int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (calm || p < 65) begin
			return 0;
		end else if (p < 95) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 80);
	endfunction

	// Monitor both channels at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (dst_valid && !dst_stall) begin
				sb.check_item(dst_data);
			end
			if (src_valid && !src_stall) begin
				sb.note_command(src_data);
			end
			if ((dst_valid && !dst_stall) || (src_valid && !src_stall)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// Result-side stall, including the one long hold-off.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			dst_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req) begin
			dst_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_req = 1'b0;
		end else if (stall_left > 0) begin
			dst_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			dst_stall <= 1'b0;
			stall_left <= pick_gap();
		end
	end

	function src_t make_cmd(logic [1:0] op, logic [31:0] ox, logic [31:0] oy,
		logic [23:0] hue, logic [5:0] cnt, logic [31:0] spd, logic [23:0] life,
		logic [15:0] dt);
		src_t c;
		c.cmd = op;
		c.origin_x = ox;
		c.origin_y = oy;
		c.tint = hue;
		c.burst_count = cnt;
		c.base_speed = spd;
		c.base_life = life;
		c.time_step = dt;
		return c;
	endfunction

	function src_t random_cmd();
		int p;
		src_t c;
		c = make_cmd(CMD_EMIT, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom);
		p = $urandom_range(0, 99);
		if (p < 35) begin
			c.cmd = CMD_EMIT;
			if ($urandom_range(0, 3) != 0) begin
				c.origin_x = $signed($urandom_range(0, 400)) - 200 <<< 16;
				c.origin_y = $signed($urandom_range(0, 400)) - 200 <<< 16;
			end
			if ($urandom_range(0, 7) != 0) begin
				c.base_speed = ($urandom_range(0, 300) << 16) | $urandom_range(0, 65535);
			end
			if ($urandom_range(0, 7) != 0) begin
				c.base_life = $urandom_range(24'h008000, 24'h040000);
			end
			if ($urandom_range(0, 5) != 0) begin
				c.burst_count = $urandom_range(1, 6);
			end
		end else if (p < 65) begin
			c.cmd = CMD_UPDATE;
			if ($urandom_range(0, 7) != 0) begin
				c.time_step = $urandom_range(0, 16'h2000);
			end
		end else if (p < 95) begin
			c.cmd = CMD_DRAW;
		end else begin
			c.cmd = CMD_UNUSED;
		end
		return c;
	endfunction

	// Offers one command transaction and holds it until accepted.
	task automatic send_cmd(src_t c, int gap);
		@(negedge clk);
		src_valid <= 1'b1;
		src_data <= c;
		do begin
			@(posedge clk);
		end while (src_stall);
		if (gap > 0) begin
			@(negedge clk);
			src_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (200) @(posedge clk);
	endtask

	initial begin
		src_t directed[$];
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty pool, zero start life, saturation, full pool and drag sign.
		directed.push_back(make_cmd(CMD_DRAW, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_cmd(CMD_UNUSED, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_cmd(CMD_UPDATE, 0, 0, 0, 0, 0, 0, 16'd1));
		directed.push_back(make_cmd(CMD_EMIT, 0, 0, 24'hFFFFFF, 6'd0, 32'hFFFFFFFF,
			24'hFFFFFF, 0));
		directed.push_back(make_cmd(CMD_EMIT, 32'h7FFFFFFF, 32'h80000000, 24'hFFFFFF,
			6'd3, 32'hFFFFFFFF, 24'hFFFFFF, 16'hFFFF));
		directed.push_back(make_cmd(CMD_EMIT, 0, 0, 0, 6'd2, 0, 0, 0));
		directed.push_back(make_cmd(CMD_DRAW, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_cmd(CMD_UPDATE, 0, 0, 0, 0, 0, 0, 16'h4000));
		directed.push_back(make_cmd(CMD_UPDATE, 0, 0, 0, 0, 0, 0, 16'h0000));
		directed.push_back(make_cmd(CMD_DRAW, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_cmd(CMD_EMIT, 32'h80000000, 32'h7FFFFFFF, 24'h123456,
			6'd63, 32'h00640000, 24'h020000, 0));
		directed.push_back(make_cmd(CMD_DRAW, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_cmd(CMD_EMIT, 0, 0, 24'hA5A5A5, 6'd5, 32'h00010000,
			24'h010000, 0));
		directed.push_back(make_cmd(CMD_UPDATE, 0, 0, 0, 0, 0, 0, 16'hFFFF));
		directed.push_back(make_cmd(CMD_DRAW, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_cmd(CMD_UPDATE, 0, 0, 0, 0, 0, 0, 16'h8000));
		directed.push_back(make_cmd(CMD_DRAW, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_cmd(CMD_UPDATE, 0, 0, 0, 0, 0, 0, 16'hFFFF));
		directed.push_back(make_cmd(CMD_DRAW, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_cmd(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom));
		foreach (directed[i]) begin
			send_cmd(directed[i], pick_gap());
		end

		// Random traffic with calm phases, one long result hold-off and one full pause.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			calm = ((i / 40) % 3) == 0;
			if (i == 100) begin
				hold_req = 1'b1;
				for (int j = 0; j < 6; j++) begin
					send_cmd(random_cmd(), 0);
				end
			end
			if (i == 200) begin
				@(negedge clk);
				src_valid <= 1'b0;
				while (sb.pending() != 0) begin
					@(posedge clk);
				end
			end
			send_cmd(random_cmd(), pick_gap());
		end
		@(negedge clk);
		src_valid <= 1'b0;

		drain();
		if (sb.pending() != 0) begin
			$error("%0d predicted results never arrived", sb.pending());
			sb.errors++;
		end
		if (sb.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ----- particle_pool_engine.f -----
rtl/core/ppe_pkg.sv
rtl/core/ppe_ram.sv
rtl/core/ppe_div.sv
rtl/core/particle_pool_engine.sv
bench/particle_pool_engine_test.sv
